// ===== hw/rtl/uart_adc_sync_and_readout_top_assert.svh =====
// ----------------------------------------------------------------------------
// uart adc sync and readout assertion macros
// Concurrent assertion helpers on clk with asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef UART_ADC_SYNC_AND_READOUT_TOP_ASSERT_SVH
`define UART_ADC_SYNC_AND_READOUT_TOP_ASSERT_SVH

`ifndef SYNTH

// property that holds in the same cycle
`define UASR_ASSERT_NOW(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("uasr assertion failed");

// consequence that holds in the cycle after the trigger
`define UASR_ASSERT_NEXT(label, trig, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error("uasr assertion failed");

`else

`define UASR_ASSERT_NOW(label, expr)
`define UASR_ASSERT_NEXT(label, trig, expr)

`endif

`endif

// ===== hw/rtl/uasr_pkg.sv =====
// ----------------------------------------------------------------------------
// uasr_pkg
// Types, codes and constants shared by the uart adc sync and readout block.
// ----------------------------------------------------------------------------
package uasr_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0]  SYNC_TX_BYTE  = 8'hAA;
    localparam logic [7:0]  SYNC_RX_BYTE  = 8'h55;
    localparam logic [2:0]  ECHO_LIMIT    = 3'd6;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;
    localparam logic [15:0] RST_TIMEOUT   = 16'd1000;
    localparam logic [15:0] RST_VREF      = 16'd330;

    // request actions
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_RX    = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_TX        = 3'd0;
    localparam logic [2:0] KIND_VOLT      = 3'd1;
    localparam logic [2:0] KIND_SYNC_DONE = 3'd2;
    localparam logic [2:0] KIND_SYNC_TO   = 3'd3;
    localparam logic [2:0] KIND_READ_TO   = 3'd4;
    localparam logic [2:0] KIND_NOT_READY = 3'd5;

    // register indexes
    localparam logic [1:0] REG_COMMAND_BASE = 2'd0;
    localparam logic [1:0] REG_SYNC_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_VREF         = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SYNC = 3'd1,
        PH_ECHO = 3'd2,
        PH_HIGH = 3'd3,
        PH_LOW  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0]  command_base;
        logic [15:0] sync_timeout_ticks;
        logic [15:0] vref_hundredths;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  tx_data;
        logic [15:0] voltage;
        logic        last;
    } result_t;

endpackage

// ===== hw/rtl/uasr_core.sv =====
// ----------------------------------------------------------------------------
// uasr_core
// Link handshake and channel readout state, one request per cycle while req_accept is high.
// ----------------------------------------------------------------------------
module uasr_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_accept,
    input  logic [1:0]        action,
    input  logic [1:0]        channel,
    input  logic [7:0]        rx_data,
    input  uasr_pkg::cfg_t    cfg,
    output uasr_pkg::result_t res0,
    output uasr_pkg::result_t res1,
    output logic [1:0]        res_cnt
);
    import uasr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        link_ready_reg, link_ready_next;
    logic        seen_sync_reg, seen_sync_next;
    logic [2:0]  echo_count_reg, echo_count_next;
    logic [7:0]  expected_echo_reg, expected_echo_next;
    logic [7:0]  high_byte_reg, high_byte_next;
    logic [15:0] tick_count_reg, tick_count_next;

    logic [15:0] tick_inc;
    logic [7:0]  command;
    logic [9:0]  code;
    logic [25:0] product;

    assign tick_inc = (tick_count_reg < TICK_MAX) ? tick_count_reg + 16'd1 : tick_count_reg;
    assign command  = cfg.command_base | {2'b00, channel, 4'b0000};
    assign code     = {high_byte_reg[3:0], rx_data[6:1]};
    assign product  = {16'd0, code} * {10'd0, cfg.vref_hundredths};

    // next state
    always_comb
    begin
        phase_next         = phase_reg;
        link_ready_next    = link_ready_reg;
        seen_sync_next     = seen_sync_reg;
        echo_count_next    = echo_count_reg;
        expected_echo_next = expected_echo_reg;
        high_byte_next     = high_byte_reg;
        tick_count_next    = tick_count_reg;
        if (req_accept)
        begin
            case (action)
                ACT_START:
                begin
                    phase_next      = PH_SYNC;
                    seen_sync_next  = 1'b0;
                    tick_count_next = 16'd0;
                end
                ACT_TICK:
                begin
                    if (phase_reg == PH_SYNC)
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= cfg.sync_timeout_ticks)
                            phase_next = PH_IDLE;
                    end
                end
                ACT_READ:
                begin
                    if (link_ready_reg)
                    begin
                        expected_echo_next = command;
                        echo_count_next    = 3'd0;
                        phase_next         = PH_ECHO;
                    end
                end
                default:
                begin
                    case (phase_reg)
                        PH_SYNC:
                        begin
                            if (rx_data == SYNC_RX_BYTE)
                            begin
                                if (seen_sync_reg)
                                begin
                                    link_ready_next = 1'b1;
                                    phase_next      = PH_IDLE;
                                end
                                else
                                    seen_sync_next = 1'b1;
                            end
                            else
                                seen_sync_next = 1'b0;
                        end
                        PH_ECHO:
                        begin
                            if (echo_count_reg >= ECHO_LIMIT)
                                phase_next = PH_IDLE;
                            else
                            begin
                                echo_count_next = echo_count_reg + 3'd1;
                                if (rx_data == expected_echo_reg)
                                    phase_next = PH_HIGH;
                            end
                        end
                        PH_HIGH:
                        begin
                            high_byte_next = rx_data;
                            phase_next     = PH_LOW;
                        end
                        PH_LOW:
                            phase_next = PH_IDLE;
                        default:
                            phase_next = phase_reg;
                    endcase
                end
            endcase
        end
    end

    // results of this request
    always_comb
    begin
        res0    = '{kind: KIND_TX, tx_data: 8'd0, voltage: 16'd0, last: 1'b1};
        res1    = '{kind: KIND_SYNC_DONE, tx_data: 8'd0, voltage: 16'd0, last: 1'b1};
        res_cnt = 2'd0;
        if (req_accept)
        begin
            case (action)
                ACT_START:
                begin
                    res0.tx_data = SYNC_TX_BYTE;
                    res_cnt      = 2'd1;
                end
                ACT_TICK:
                begin
                    if (phase_reg == PH_SYNC && tick_inc >= cfg.sync_timeout_ticks)
                    begin
                        res0.kind = KIND_SYNC_TO;
                        res_cnt   = 2'd1;
                    end
                end
                ACT_READ:
                begin
                    res_cnt = 2'd1;
                    if (link_ready_reg)
                        res0.tx_data = command;
                    else
                        res0.kind = KIND_NOT_READY;
                end
                default:
                begin
                    case (phase_reg)
                        PH_SYNC:
                        begin
                            res0.tx_data = SYNC_TX_BYTE;
                            if (rx_data == SYNC_RX_BYTE && seen_sync_reg)
                            begin
                                res0.last = 1'b0;
                                res_cnt   = 2'd2;
                            end
                            else
                                res_cnt = 2'd1;
                        end
                        PH_ECHO:
                        begin
                            if (echo_count_reg >= ECHO_LIMIT)
                            begin
                                res0.kind = KIND_READ_TO;
                                res_cnt   = 2'd1;
                            end
                        end
                        PH_LOW:
                        begin
                            res0.kind    = KIND_VOLT;
                            res0.voltage = product[25:10];
                            res_cnt      = 2'd1;
                        end
                        default:
                            res_cnt = 2'd0;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            link_ready_reg    <= 1'b0;
            seen_sync_reg     <= 1'b0;
            echo_count_reg    <= 3'd0;
            expected_echo_reg <= 8'd0;
            high_byte_reg     <= 8'd0;
            tick_count_reg    <= 16'd0;
        end
        else
        begin
            phase_reg         <= phase_next;
            link_ready_reg    <= link_ready_next;
            seen_sync_reg     <= seen_sync_next;
            echo_count_reg    <= echo_count_next;
            expected_echo_reg <= expected_echo_next;
            high_byte_reg     <= high_byte_next;
            tick_count_reg    <= tick_count_next;
        end
    end

`include "uart_adc_sync_and_readout_top_assert.svh"

    // once up, the link stays up
    `UASR_ASSERT_NOW(a_link_kept, !$fell(link_ready_reg))
    // a pair of results only ever closes the handshake
    `UASR_ASSERT_NEXT(a_pair_done, res_cnt == 2'd2, link_ready_reg && phase_reg == PH_IDLE)
    // the echo wait never counts past its limit
    `UASR_ASSERT_NOW(a_echo_bound, echo_count_reg <= ECHO_LIMIT)

endmodule

// ===== hw/rtl/uasr_queue.sv =====
// ----------------------------------------------------------------------------
// uasr_queue
// Result queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module uasr_queue #(
    parameter int unsigned DEPTH = uasr_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_cnt,
    input  uasr_pkg::result_t push0,
    input  uasr_pkg::result_t push1,
    output logic              room,
    output logic              head_valid,
    output uasr_pkg::result_t head,
    input  logic              pop
);
    import uasr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

    result_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] wr_ptr_inc2;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    assign wr_ptr_inc  = ptr_step(wr_ptr_reg);
    assign wr_ptr_inc2 = ptr_step(wr_ptr_inc);
    assign do_pop      = pop && (count_reg != '0);
    assign room        = (count_reg <= ROOM_MAX);
    assign head_valid  = (count_reg != '0);
    assign head        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        case (push_cnt)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = wr_ptr_inc2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = do_pop ? ptr_step(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            mem_reg[wr_ptr_inc] <= push1;
    end

`include "uart_adc_sync_and_readout_top_assert.svh"

    `UASR_ASSERT_NOW(a_cnt_bound, count_reg <= CNT_W'(DEPTH))
    // pushes only land while there is room for a pair
    `UASR_ASSERT_NOW(a_push_room, push_cnt == 2'd0 || room)
    `UASR_ASSERT_NEXT(a_pair_count, push_cnt == 2'd2 && !do_pop,
                      count_reg == $past(count_reg) + CNT_W'(2))

endmodule

// ===== hw/rtl/uart_adc_sync_and_readout_top.sv =====
// ----------------------------------------------------------------------------
// uart_adc_sync_and_readout_top
// Host-side link handshake and channel readout for a serial-linked converter.
// ----------------------------------------------------------------------------
// One request is taken every cycle: its state update, the 10 x 16 voltage
// multiply and the result write all happen in the accepting cycle, and the
// results wait in a queue (QUEUE_DEPTH deep, four by default) until taken on
// the master side. A byte that closes the handshake gives two results, every
// other request gives at most one; s_tready is high while the queue has room
// for two results, so the output side paces the block at one result a cycle.
module uart_adc_sync_and_readout_top #(
    parameter int unsigned QUEUE_DEPTH = uasr_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // channel[1:0], rx_data[9:2], zero fill
    input  logic [1:0]  s_tuser,   // action[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // tx_data[7:0], voltage[23:8]
    output logic [2:0]  m_tuser,   // kind[2:0]
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import uasr_pkg::*;

    cfg_t        cfg_reg;
    logic        cfg_write;
    logic [1:0]  reg_index;
    logic        req_accept;
    result_t     res0;
    result_t     res1;
    logic [1:0]  res_cnt;
    logic        room;
    result_t     head;

    assign pready     = 1'b1;
    assign reg_index  = paddr[3:2];
    assign cfg_write  = psel && penable && pwrite && pready;
    assign req_accept = s_tvalid && s_tready;
    assign s_tready   = room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.command_base       <= 8'd0;
            cfg_reg.sync_timeout_ticks <= RST_TIMEOUT;
            cfg_reg.vref_hundredths    <= RST_VREF;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_COMMAND_BASE: cfg_reg.command_base       <= pwdata[7:0];
                REG_SYNC_TIMEOUT: cfg_reg.sync_timeout_ticks <= pwdata[15:0];
                REG_VREF:         cfg_reg.vref_hundredths    <= pwdata[15:0];
                default:          cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_COMMAND_BASE: prdata = {24'd0, cfg_reg.command_base};
            REG_SYNC_TIMEOUT: prdata = {16'd0, cfg_reg.sync_timeout_ticks};
            REG_VREF:         prdata = {16'd0, cfg_reg.vref_hundredths};
            default:          prdata = 32'd0;
        endcase
    end

    uasr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_accept (req_accept),
        .action     (s_tuser),
        .channel    (s_tdata[1:0]),
        .rx_data    (s_tdata[9:2]),
        .cfg        (cfg_reg),
        .res0       (res0),
        .res1       (res1),
        .res_cnt    (res_cnt)
    );

    uasr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (res_cnt),
        .push0      (res0),
        .push1      (res1),
        .room       (room),
        .head_valid (m_tvalid),
        .head       (head),
        .pop        (m_tready)
    );

    assign m_tdata = {head.voltage, head.tx_data};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule
